// ===== rtl/psstat_pkg.sv =====
// Shared constants for the per-slot statistics block.
package psstat_pkg;

  localparam int Slots      = 8;
  localparam int ActionW    = 2;
  localparam int TaskIdW    = 3;
  localparam int TicksW     = 32;
  localparam int SumW       = 64;
  localparam int DividendW  = 64;
  localparam int DivisorW   = 32;
  localparam int ScaleW     = 27;
  localparam int ProdW      = TicksW + ScaleW;

  // hundredths of a microsecond per second
  localparam logic [ScaleW-1:0] Us100PerSec = ScaleW'(100000000);

  localparam logic [ActionW-1:0] ActRecord = 2'd0;
  localparam logic [ActionW-1:0] ActRead   = 2'd1;
  localparam logic [ActionW-1:0] ActClear  = 2'd2;

endpackage

// ===== rtl/psstat_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
module psstat_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [psstat_pkg::DividendW-1:0]    dividend_i,
  input  logic [psstat_pkg::DivisorW-1:0]     divisor_i,
  output logic                                done_o,
  output logic [psstat_pkg::TicksW-1:0]       quotient_o
);

  localparam int StepW = $clog2(psstat_pkg::DividendW);

  logic [psstat_pkg::DividendW-1:0] dvd_q;
  logic [psstat_pkg::DivisorW-1:0]  dvs_q;
  logic [psstat_pkg::DivisorW-1:0]  rem_q;
  logic [StepW-1:0]                 step_q;
  logic                             busy_q;
  logic                             done_q;
  logic [psstat_pkg::DivisorW:0]    trial;
  logic                             fits;

  assign trial = {rem_q, dvd_q[psstat_pkg::DividendW-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
      dvd_q  <= '0;
      dvs_q  <= '0;
      rem_q  <= '0;
    end else begin
      done_q <= busy_q && !start_i && (step_q == '0);
      if (start_i) begin
        dvd_q  <= dividend_i;
        dvs_q  <= divisor_i;
        rem_q  <= '0;
        step_q <= StepW'(psstat_pkg::DividendW - 1);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        // shift quotient bits in from the bottom as dividend bits leave the top
        dvd_q <= {dvd_q[psstat_pkg::DividendW-2:0], fits};
        rem_q <= fits ? psstat_pkg::DivisorW'(trial - {1'b0, dvs_q})
                      : trial[psstat_pkg::DivisorW-1:0];
        if (step_q == '0) begin
          busy_q <= 1'b0;
        end else begin
          step_q <= step_q - StepW'(1);
        end
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = dvd_q[psstat_pkg::TicksW-1:0];

endmodule

// ===== rtl/per_slot_min_max_mean_statistics.sv =====
// Per-slot min/max/mean statistics table with converted read-out.
//
//  channel  | dir | handshake                    | payload
//  ---------+-----+------------------------------+------------------------------------
//  cfg      | in  | cfg_valid_i / cfg_ready_o    | cfg_data_i: tick rate in hertz
//  s_axis   | in  | s_axis_tvalid / s_axis_tready| tuser: action; tdata: task_id, cycles
//  m_axis   | out | m_axis_tvalid / m_axis_tready| tdata: count, min, mean, max
//
// Record and clear update the table on acceptance; unused actions do nothing.
// A read runs one shared 64-bit divider, one bit per cycle: the mean first, then
// max, min and mean conversions; an empty slot converts only max, a zero tick
// rate none. Reset empties every slot at once and zeroes the tick rate.
// The result sits in an output register; a new request is taken while it waits.
module per_slot_min_max_mean_statistics #(
  parameter int SLOTS = psstat_pkg::Slots
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [psstat_pkg::TicksW-1:0]  cfg_data_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [39:0]                    s_axis_tdata,  // task_id[2:0], cycles[34:3]
  input  logic [1:0]                     s_axis_tuser,  // action[1:0]
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [127:0]                   m_axis_tdata   // count, min, mean, max
);

  localparam int TW    = psstat_pkg::TicksW;
  localparam int Reach = 1 << psstat_pkg::TaskIdW;
  localparam int Depth = (SLOTS < Reach) ? SLOTS : Reach;
  localparam int IdxW  = (Depth > 1) ? $clog2(Depth) : 1;

  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] SMul  = 3'd1;
  localparam logic [2:0] SLoad = 3'd2;
  localparam logic [2:0] SDiv  = 3'd3;
  localparam logic [2:0] SFin  = 3'd4;

  localparam logic [1:0] JobMean = 2'd0;
  localparam logic [1:0] JobMax  = 2'd1;
  localparam logic [1:0] JobMin  = 2'd2;
  localparam logic [1:0] JobAvg  = 2'd3;

  logic [TW-1:0]              rate_q;
  logic [TW-1:0]              count_q [Depth];
  logic [TW-1:0]              min_q   [Depth];
  logic [TW-1:0]              max_q   [Depth];
  logic [psstat_pkg::SumW-1:0] sum_q  [Depth];

  logic [2:0]    state_q;
  logic [1:0]    job_q;
  logic [TW-1:0] cnt_w_q, min_w_q, max_w_q, mean_w_q;
  logic [TW-1:0] res_cnt_q, res_min_q, res_avg_q, res_max_q;
  logic [psstat_pkg::ProdW-1:0] prod_q;
  logic          m_valid_q;
  logic [127:0]  m_data_q;

  logic [psstat_pkg::ActionW-1:0] in_action;
  logic [psstat_pkg::TaskIdW-1:0] in_tid;
  logic [TW-1:0]                  in_cycles;
  logic                           accept;
  logic                           slot_hit;
  logic [IdxW-1:0]                idx;
  logic                           rd_go;
  logic                           div_start;
  logic [psstat_pkg::DividendW-1:0] div_dividend;
  logic [psstat_pkg::DivisorW-1:0]  div_divisor;
  logic                           div_done;
  logic [TW-1:0]                  div_quot;
  logic [TW-1:0]                  ticks_sel;

  assign in_action = s_axis_tuser[psstat_pkg::ActionW-1:0];
  assign in_tid    = s_axis_tdata[psstat_pkg::TaskIdW-1:0];
  assign in_cycles = s_axis_tdata[psstat_pkg::TaskIdW +: TW];

  assign s_axis_tready = (state_q == SIdle);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign slot_hit      = 32'(in_tid) < 32'(Depth);
  assign idx           = IdxW'(in_tid);
  assign rd_go         = accept && (in_action == psstat_pkg::ActRead);

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q <= '0;
    end else if (cfg_valid_i) begin
      rate_q <= cfg_data_i;
    end
  end

  // slot table
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Depth; i++) begin
        count_q[i] <= '0;
        min_q[i]   <= '1;
        max_q[i]   <= '0;
        sum_q[i]   <= '0;
      end
    end else if (accept && in_action == psstat_pkg::ActClear) begin
      for (int i = 0; i < Depth; i++) begin
        count_q[i] <= '0;
        min_q[i]   <= '1;
        max_q[i]   <= '0;
        sum_q[i]   <= '0;
      end
    end else if (accept && in_action == psstat_pkg::ActRecord && slot_hit) begin
      count_q[idx] <= count_q[idx] + TW'(1);
      sum_q[idx]   <= sum_q[idx] + psstat_pkg::SumW'(in_cycles);
      if (in_cycles > max_q[idx]) begin
        max_q[idx] <= in_cycles;
      end
      if (in_cycles < min_q[idx]) begin
        min_q[idx] <= in_cycles;
      end
    end
  end

  always_comb begin
    case (job_q)
      JobMax:  ticks_sel = max_w_q;
      JobMin:  ticks_sel = min_w_q;
      default: ticks_sel = mean_w_q;
    endcase
  end

  // mean division starts straight from the table; conversions from the product
  assign div_start = (rd_go && slot_hit && count_q[idx] != '0) || (state_q == SLoad);

  always_comb begin
    if (state_q == SIdle) begin
      div_dividend = sum_q[idx];
      div_divisor  = count_q[idx];
    end else begin
      div_dividend = psstat_pkg::DividendW'(prod_q)
                   + psstat_pkg::DividendW'(rate_q[TW-1:1]);
      div_divisor  = rate_q;
    end
  end

  psstat_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  // read sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= SIdle;
      job_q     <= JobMean;
      cnt_w_q   <= '0;
      min_w_q   <= '0;
      max_w_q   <= '0;
      mean_w_q  <= '0;
      res_cnt_q <= '0;
      res_min_q <= '0;
      res_avg_q <= '0;
      res_max_q <= '0;
      prod_q    <= '0;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
    end else begin
      if (m_valid_q && m_axis_tready && state_q != SFin) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        SIdle: begin
          if (rd_go) begin
            res_min_q <= '0;
            res_avg_q <= '0;
            res_max_q <= '0;
            if (slot_hit) begin
              cnt_w_q   <= count_q[idx];
              min_w_q   <= min_q[idx];
              max_w_q   <= max_q[idx];
              res_cnt_q <= count_q[idx];
              if (count_q[idx] != '0) begin
                job_q   <= JobMean;
                state_q <= SDiv;
              end else if (rate_q != '0) begin
                job_q   <= JobMax;
                state_q <= SMul;
              end else begin
                state_q <= SFin;
              end
            end else begin
              res_cnt_q <= '0;
              state_q   <= SFin;
            end
          end
        end
        SMul: begin
          prod_q  <= psstat_pkg::ProdW'(ticks_sel) * psstat_pkg::ProdW'(psstat_pkg::Us100PerSec);
          state_q <= SLoad;
        end
        SLoad: begin
          state_q <= SDiv;
        end
        SDiv: begin
          if (div_done) begin
            case (job_q)
              JobMean: begin
                mean_w_q <= div_quot;
                if (rate_q != '0) begin
                  job_q   <= JobMax;
                  state_q <= SMul;
                end else begin
                  state_q <= SFin;
                end
              end
              JobMax: begin
                res_max_q <= div_quot;
                if (cnt_w_q != '0) begin
                  job_q   <= JobMin;
                  state_q <= SMul;
                end else begin
                  state_q <= SFin;
                end
              end
              JobMin: begin
                res_min_q <= div_quot;
                job_q     <= JobAvg;
                state_q   <= SMul;
              end
              default: begin
                res_avg_q <= div_quot;
                state_q   <= SFin;
              end
            endcase
          end
        end
        SFin: begin
          // hold until the output register is free
          if (!m_valid_q || m_axis_tready) begin
            m_valid_q <= 1'b1;
            m_data_q  <= {res_max_q, res_avg_q, res_min_q, res_cnt_q};
            state_q   <= SIdle;
          end
        end
        default: begin
          state_q <= SIdle;
        end
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking stream testbench for the per-slot min/max/mean statistics table.
module testbench;
  import psstat_pkg::*;

  localparam logic [ActionW-1:0] ActUnused = 2'd3;
  localparam int PhaseItems   = 180;
  localparam int HoldCycles   = 1500;
  localparam int SettleCycles = 300;
  // at this rate a converted time equals the tick count
  localparam logic [31:0] RateUnity = 32'd100_000_000;

  typedef struct packed {
    logic [31:0] max_v;
    logic [31:0] avg_v;
    logic [31:0] min_v;
    logic [31:0] count;
  } stats_t;

  typedef struct {
    logic [31:0]        rate;
    logic [ActionW-1:0] act;
    logic [TaskIdW-1:0] slot;
    logic [TicksW-1:0]  ticks;
    bit                 typed;
    stats_t             want;
  } step_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [TicksW-1:0]  cfg_data_i = '0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [39:0]        s_axis_tdata = '0;  // task_id[2:0], cycles[34:3]
  logic [1:0]         s_axis_tuser = '0;  // action[1:0]
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [127:0]       m_axis_tdata;       // count, min, mean, max

  // predictor state
  logic [31:0] tick_rate_model;
  logic [31:0] slot_samples [Slots];
  logic [31:0] slot_lo [Slots];
  logic [31:0] slot_hi [Slots];
  logic [63:0] slot_total [Slots];
  stats_t      expected_stats [$];
  step_row_t   directed_rows [$];

  int  phase_idx = -1;
  bit  idle_enable = 1'b1;
  int  mismatches = 0;
  int  results_checked = 0;
  int  requests_sent = 0;
  int  reads_sent = 0;
  int  rates_used = 0;

  per_slot_min_max_mean_statistics dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  function automatic void clear_table();
    for (int i = 0; i < Slots; i++) begin
      slot_samples[i] = '0;
      slot_lo[i]      = '1;
      slot_hi[i]      = '0;
      slot_total[i]   = '0;
    end
  endfunction

  function automatic logic [31:0] to_us_x100(input logic [31:0] ticks);
    logic [63:0] num;
    if (tick_rate_model == '0) return '0;
    num = 64'(ticks) * 64'(Us100PerSec) + 64'(tick_rate_model >> 1);
    return 32'(num / 64'(tick_rate_model));
  endfunction

  // Update the slot table for one accepted request; queue the stats a read returns.
  function automatic void apply_request(input logic [ActionW-1:0] act,
                                        input logic [TaskIdW-1:0] slot,
                                        input logic [TicksW-1:0] ticks);
    stats_t s;
    case (act)
      ActRecord: begin
        slot_samples[slot] += 32'd1;
        slot_total[slot]   += 64'(ticks);
        if (ticks > slot_hi[slot]) slot_hi[slot] = ticks;
        if (ticks < slot_lo[slot]) slot_lo[slot] = ticks;
      end
      ActClear: clear_table();
      ActRead: begin
        s.count = slot_samples[slot];
        s.max_v = to_us_x100(slot_hi[slot]);
        if (s.count != '0) begin
          s.min_v = to_us_x100(slot_lo[slot]);
          s.avg_v = to_us_x100(32'(slot_total[slot] / 64'(s.count)));
        end else begin
          s.min_v = '0;
          s.avg_v = '0;
        end
        expected_stats.push_back(s);
      end
      default: ;
    endcase
  endfunction

  function automatic void add_step(input logic [31:0] rate, input logic [ActionW-1:0] act,
                                   input logic [TaskIdW-1:0] slot,
                                   input logic [TicksW-1:0] ticks);
    step_row_t r;
    r.rate  = rate;
    r.act   = act;
    r.slot  = slot;
    r.ticks = ticks;
    r.typed = 1'b0;
    r.want  = '0;
    directed_rows.push_back(r);
  endfunction

  function automatic void add_read_check(input logic [31:0] rate,
                                         input logic [TaskIdW-1:0] slot,
                                         input logic [31:0] cnt, input logic [31:0] mn,
                                         input logic [31:0] av, input logic [31:0] mx);
    step_row_t r;
    r.rate  = rate;
    r.act   = ActRead;
    r.slot  = slot;
    r.ticks = '0;
    r.typed = 1'b1;
    r.want  = '{max_v: mx, avg_v: av, min_v: mn, count: cnt};
    directed_rows.push_back(r);
  endfunction

  function automatic void note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("[%0t] MISMATCH %s", $realtime, msg);
  endfunction

  task automatic send_request(input logic [ActionW-1:0] act, input logic [TaskIdW-1:0] slot,
                              input logic [TicksW-1:0] ticks, input bit typed,
                              input stats_t want);
    s_axis_tuser  <= act;
    s_axis_tdata  <= {5'b0, ticks, slot};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    requests_sent++;
    if (act == ActRead) reads_sent++;
    if (typed) expected_stats.push_back(want);
    else apply_request(act, slot, ticks);
    if (idle_enable && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
  endtask

  task automatic send_random_request(output bit counted);
    logic [ActionW-1:0] act;
    logic [TicksW-1:0]  ticks;
    int                 pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) act = ActRecord;
    else if (pick < 88) act = ActRead;
    else if (pick < 91) act = ActClear;
    else act = ActUnused;
    case ($urandom_range(0, 9))
      0: ticks = '0;
      1: ticks = '1;
      2, 3: ticks = 32'($urandom_range(0, 5000));
      default: ticks = $urandom();
    endcase
    send_request(act, TaskIdW'($urandom_range(0, Slots - 1)), ticks, 1'b0, '0);
    counted = (act != ActUnused);
  endtask

  // Hold until every read has returned, then let a slow request finish.
  task automatic wait_until_idle();
    s_axis_tvalid <= 1'b0;
    while (expected_stats.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_rate(input logic [31:0] rate);
    cfg_data_i  <= rate;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i     <= 1'b0;
    tick_rate_model = rate;
    rates_used++;
  endtask

  initial begin : stimulus
    logic [31:0] phase_rates [6];
    int          counted_items;
    bit          counted;
    phase_rates = '{32'd72_000_000, 32'd1, 32'hFFFF_FFFF, 32'd0, $urandom(),
                    32'd1_000_000};
    tick_rate_model = '0;
    clear_table();

    add_read_check(0, 0, 0, 0, 0, 0);
    add_step(0, ActRecord, 1, '1);
    add_step(0, ActRecord, 1, '0);
    // zero tick rate: every time reads zero
    add_read_check(0, 1, 2, 0, 0, 0);
    add_step(0, ActUnused, 1, 32'h1234_5678);
    add_read_check(0, 1, 2, 0, 0, 0);
    add_step(0, ActClear, 0, '0);
    add_read_check(0, 1, 0, 0, 0, 0);
    add_read_check(RateUnity, 1, 0, 0, 0, 0);
    add_step(RateUnity, ActRecord, 7, '1);
    add_step(RateUnity, ActRecord, 7, 32'd1);
    add_read_check(RateUnity, 7, 2, 1, 32'h8000_0000, '1);
    add_step(RateUnity, ActRecord, 0, 32'hAAAA_AAAA);
    add_step(RateUnity, ActRecord, 0, 32'h5555_5555);
    add_read_check(RateUnity, 0, 2, 32'h5555_5555, 32'h7FFF_FFFF, 32'hAAAA_AAAA);
    add_step(RateUnity, ActUnused, 7, '1);
    add_read_check(RateUnity, 7, 2, 1, 32'h8000_0000, '1);
    add_step(32'hFFFF_FFFF, ActRead, 0, '0);
    add_step(32'd1, ActRead, 7, '0);
    add_step(32'd1, ActClear, 7, '1);
    add_step(32'd1, ActRead, 0, '0);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].rate != tick_rate_model) begin
        wait_until_idle();
        write_rate(directed_rows[i].rate);
      end
      send_request(directed_rows[i].act, directed_rows[i].slot, directed_rows[i].ticks,
                   directed_rows[i].typed, directed_rows[i].want);
    end

    for (int p = 0; p < 6; p++) begin
      wait_until_idle();
      phase_idx   = p;
      idle_enable = (p != 5);
      write_rate(phase_rates[p]);
      counted_items = 0;
      while (counted_items < PhaseItems) begin
        send_random_request(counted);
        if (counted) counted_items++;
      end
    end
    wait_until_idle();

    $display("Ran %0d requests (%0d reads) under %0d tick-rate writes; %0d results checked.",
             requests_sent, reads_sent, rates_used, results_checked);
    if (mismatches > 10) $display("%0d mismatches in total", mismatches);
    if (mismatches == 0 && expected_stats.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin : result_sink
    bit held;
    held = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (!held && phase_idx == 1) begin
        // stall the output long enough for the input to back up
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else if (idle_enable && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    stats_t got;
    stats_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      results_checked++;
      if (expected_stats.size() == 0) begin
        note_mismatch($sformatf("result %h with no read pending", got));
      end else begin
        want = expected_stats.pop_front();
        if (got.count !== want.count)
          note_mismatch($sformatf("count exp %h got %h", want.count, got.count));
        if (got.min_v !== want.min_v)
          note_mismatch($sformatf("min exp %h got %h", want.min_v, got.min_v));
        if (got.avg_v !== want.avg_v)
          note_mismatch($sformatf("mean exp %h got %h", want.avg_v, got.avg_v));
        if (got.max_v !== want.max_v)
          note_mismatch($sformatf("max exp %h got %h", want.max_v, got.max_v));
      end
    end
  end

  initial begin : watchdog
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/psstat_pkg.sv
rtl/psstat_div.sv
rtl/per_slot_min_max_mean_statistics.sv
test/testbench.sv
